/* rtl/imu_sample_time_sync_interpolator_defines.svh */
// Assertion helpers for the IMU time-sync interpolator.
`ifndef IMU_SAMPLE_TIME_SYNC_INTERPOLATOR_DEFINES_SVH
`define IMU_SAMPLE_TIME_SYNC_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define IMUSYNC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imusync check failed");

// Next-cycle implication.
`define IMUSYNC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imusync check failed");

`endif

/* rtl/imusync_pkg.sv */
package imusync_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int AW           = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = AW + 1;

    localparam int STAMP_W    = 48;
    localparam int MOTION_W   = 32;
    localparam int QUAT_W     = 16;
    localparam int GAP_W      = 24;
    localparam int STATUS_W   = 3;
    localparam int NUM_MOTION = 6;
    localparam int NUM_QUAT   = 4;
    localparam int NUM_CHAN   = NUM_MOTION + NUM_QUAT;
    localparam int QUAT_BASE  = STAMP_W + NUM_MOTION * MOTION_W;
    localparam int ENTRY_W    = QUAT_BASE + NUM_QUAT * QUAT_W;
    localparam int CH_W       = 4;
    localparam int W_W        = 25;
    localparam int PROD_W     = 57;
    localparam int ACC_W      = 58;
    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 32;
    localparam int SUM_W      = 34;
    localparam int NORM_SHIFT = 28;

    localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_SYNC = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_EARLY = 3'd2,
        STAT_FEW   = 3'd3,
        STAT_GAP   = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PUSH,
        ST_WALK,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_CMP,
        ST_COPY,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_NRM_GO,
        ST_NRM_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] head,
                                               input logic [CNT_W-1:0] k);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(k);
        if (sum >= (CNT_W+1)'(BUFFER_DEPTH))
            sum = sum - (CNT_W+1)'(BUFFER_DEPTH);
        return sum[AW-1:0];
    endfunction

    function automatic logic signed [MOTION_W-1:0] chan_val(input logic [ENTRY_W-1:0] entry,
                                                            input logic [CH_W-1:0] ch);
        logic [MOTION_W-1:0] m;
        logic [QUAT_W-1:0]   q;
        m = '0;
        q = '0;
        for (int i = 0; i < NUM_MOTION; i++)
            if (ch == CH_W'(i))
                m = entry[STAMP_W + i*MOTION_W +: MOTION_W];
        for (int i = 0; i < NUM_QUAT; i++)
            if (ch == CH_W'(NUM_MOTION + i))
                q = entry[QUAT_BASE + i*QUAT_W +: QUAT_W];
        if (ch < CH_W'(NUM_MOTION))
            return $signed(m);
        else
            return MOTION_W'($signed(q));
    endfunction

endpackage

/* rtl/imusync_ram.sv */
module imusync_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/imusync_div.sv */
module imusync_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imusync_pkg::div_req_t               req,
    output logic                                done,
    output logic [imusync_pkg::DIV_N_W-1:0]     quot
);
    import imusync_pkg::*;

    logic               run_reg;
    logic               done_reg;
    logic [6:0]         cnt_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [DIV_D_W:0]   shifted;
    logic               fits;

    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_N_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? DIV_D_W'(shifted - {1'b0, dvs_reg}) : shifted[DIV_D_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* rtl/imusync_sqrt.sv */
module imusync_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [imusync_pkg::DIV_N_W-1:0] radicand,
    output logic                            done,
    output logic [imusync_pkg::DIV_D_W-1:0] root
);
    import imusync_pkg::*;

    logic               run_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic [DIV_N_W-1:0] v_reg;
    logic [DIV_N_W-1:0] res_reg;
    logic [DIV_N_W-1:0] bit_reg;
    logic [DIV_N_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= DIV_N_W'(1) << 62;
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[DIV_D_W-1:0];

endmodule

/* rtl/imu_sample_time_sync_interpolator.sv */
// Timestamped IMU sample buffer with linear interpolation at a requested time.
// Pulse start with a push (store a sample) or a sync (interpolate at stamp);
// busy stays high until the single result appears on the output ports for one
// cycle with done high. The receiver cannot stall: capture the result on done.
// A sync walks the buffer, one step through WALK, RD0, RD1, RD2 and CMP per
// bracket tried, then runs each of the 10 channels through the shared 64-step
// divider, takes the quaternion square root and normalizes each quaternion
// component through the same divider. With equal bracket stamps the channel
// divisions are skipped.
`include "imu_sample_time_sync_interpolator_defines.svh"

module imu_sample_time_sync_interpolator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [imusync_pkg::GAP_W-1:0]          cfg_wr_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   req_type,
    input  logic [imusync_pkg::STAMP_W-1:0]        stamp,
    input  logic signed [imusync_pkg::MOTION_W-1:0] gyro_x,
    input  logic signed [imusync_pkg::MOTION_W-1:0] gyro_y,
    input  logic signed [imusync_pkg::MOTION_W-1:0] gyro_z,
    input  logic signed [imusync_pkg::MOTION_W-1:0] accel_x,
    input  logic signed [imusync_pkg::MOTION_W-1:0] accel_y,
    input  logic signed [imusync_pkg::MOTION_W-1:0] accel_z,
    input  logic signed [imusync_pkg::QUAT_W-1:0]   quat_w,
    input  logic signed [imusync_pkg::QUAT_W-1:0]   quat_x,
    input  logic signed [imusync_pkg::QUAT_W-1:0]   quat_y,
    input  logic signed [imusync_pkg::QUAT_W-1:0]   quat_z,
    output logic                                   done,
    output logic [imusync_pkg::STATUS_W-1:0]       status,
    output logic [imusync_pkg::STAMP_W-1:0]        out_stamp,
    output logic signed [imusync_pkg::MOTION_W-1:0] out_gyro_x,
    output logic signed [imusync_pkg::MOTION_W-1:0] out_gyro_y,
    output logic signed [imusync_pkg::MOTION_W-1:0] out_gyro_z,
    output logic signed [imusync_pkg::MOTION_W-1:0] out_accel_x,
    output logic signed [imusync_pkg::MOTION_W-1:0] out_accel_y,
    output logic signed [imusync_pkg::MOTION_W-1:0] out_accel_z,
    output logic signed [imusync_pkg::QUAT_W-1:0]   out_quat_w,
    output logic signed [imusync_pkg::QUAT_W-1:0]   out_quat_x,
    output logic signed [imusync_pkg::QUAT_W-1:0]   out_quat_y,
    output logic signed [imusync_pkg::QUAT_W-1:0]   out_quat_z
);
    import imusync_pkg::*;

    state_t state_reg, state_next;

    logic [AW-1:0]    head_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [GAP_W-1:0] max_gap_reg;
    logic [CH_W-1:0]  idx_reg;

    logic                req_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [ENTRY_W-1:0]  in_entry_reg;
    logic [ENTRY_W-1:0]  e0_reg;
    logic [ENTRY_W-1:0]  e1_reg;
    logic [GAP_W-1:0]    wa_reg;
    logic [GAP_W-1:0]    wb_reg;
    logic [W_W-1:0]      d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [DIV_D_W-1:0]  root_reg;
    logic signed [MOTION_W-1:0] ch_res_reg [NUM_CHAN];
    logic signed [QUAT_W-1:0]   qn_reg [NUM_QUAT];
    status_t             status_reg;
    logic [STAMP_W-1:0]  ostamp_reg;

    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quot;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [DIV_D_W-1:0] sqrt_root;

    logic signed [MOTION_W-1:0] mul_a;
    logic signed [W_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    logic [STAMP_W-1:0] t0, t1;
    logic               early, passed, gap_bad;
    logic [STAMP_W-1:0] lo_gap, hi_gap, span;

    logic signed [ACC_W-1:0]    num_sum;
    logic                       num_neg;
    logic [ACC_W-1:0]           num_mag;
    logic signed [MOTION_W-1:0] qv;
    logic                       q_neg;
    logic [MOTION_W-1:0]        q_mag;
    logic [CH_W-1:0]            q_ch;

    assign accept = start && (state_reg == ST_IDLE);

    assign t0      = e0_reg[STAMP_W-1:0];
    assign t1      = e1_reg[STAMP_W-1:0];
    assign early   = t0 > stamp_reg;
    assign passed  = t1 < stamp_reg;
    assign lo_gap  = stamp_reg - t0;
    assign hi_gap  = t1 - stamp_reg;
    assign span    = t1 - t0;
    assign gap_bad = (lo_gap > STAMP_W'(max_gap_reg)) || (hi_gap > STAMP_W'(max_gap_reg));

    assign num_sum = ACC_W'(acc_reg) + ACC_W'(prod_reg);
    assign num_neg = num_sum[ACC_W-1];
    assign num_mag = num_neg ? ACC_W'(-num_sum) : ACC_W'(num_sum);

    assign q_ch  = CH_W'(NUM_MOTION) + idx_reg;
    assign qv    = ch_res_reg[q_ch];
    assign q_neg = qv[MOTION_W-1];
    assign q_mag = q_neg ? MOTION_W'(-qv) : MOTION_W'(qv);

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    imusync_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_entry_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    imusync_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    imusync_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (DIV_N_W'(sum_reg) << NORM_SHIFT),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = (req_type == REQ_PUSH) ? ST_PUSH : ST_WALK;
            end
            ST_PUSH:      state_next = ST_DONE;
            ST_WALK:      state_next = (fill_reg < CNT_W'(2)) ? ST_DONE : ST_RD0;
            ST_RD0:       state_next = ST_RD1;
            ST_RD1:       state_next = ST_RD2;
            ST_RD2:       state_next = ST_CMP;
            ST_CMP:
            begin
                if (early)
                    state_next = ST_DONE;
                else if (passed)
                    state_next = ST_WALK;
                else if (gap_bad)
                    state_next = ST_DONE;
                else if (span == '0)
                    state_next = ST_COPY;
                else
                    state_next = ST_MUL_A;
            end
            ST_COPY:      state_next = ST_SQ_MUL;
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_DIV_GO;
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (idx_reg == CH_W'(NUM_CHAN - 1)) ? ST_SQ_MUL : ST_MUL_A;
            end
            ST_SQ_MUL:    state_next = ST_SQ_ADD;
            ST_SQ_ADD:
                state_next = (idx_reg == CH_W'(NUM_QUAT - 1)) ? ST_SQRT_GO : ST_SQ_MUL;
            ST_SQRT_GO:   state_next = (sum_reg == '0) ? ST_DONE : ST_SQRT_WAIT;
            ST_SQRT_WAIT: state_next = sqrt_done ? ST_NRM_GO : ST_SQRT_WAIT;
            ST_NRM_GO:    state_next = ST_NRM_WAIT;
            ST_NRM_WAIT:
            begin
                if (div_done)
                    state_next = (idx_reg == CH_W'(NUM_QUAT - 1)) ? ST_DONE : ST_NRM_GO;
            end
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = state_reg != ST_IDLE;
        done         = state_reg == ST_DONE;
        ram_we       = (state_reg == ST_PUSH) && (fill_reg < CNT_W'(BUFFER_DEPTH));
        ram_waddr    = slot_add(head_reg, fill_reg);
        ram_raddr    = (state_reg == ST_RD1) ? slot_add(head_reg, CNT_W'(1)) : head_reg;
        sqrt_start   = (state_reg == ST_SQRT_GO) && (sum_reg != '0);
        div_req      = '0;
        mul_a        = chan_val(e0_reg, idx_reg);
        mul_b        = $signed({1'b0, wa_reg});
        unique case (state_reg)
            ST_MUL_B:
            begin
                mul_a = chan_val(e1_reg, idx_reg);
                mul_b = $signed({1'b0, wb_reg});
            end
            ST_SQ_MUL:
            begin
                mul_a = qv;
                mul_b = W_W'(qv);
            end
            ST_DIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(num_mag) + DIV_N_W'(d_reg >> 1);
                div_req.divisor  = DIV_D_W'(d_reg);
            end
            ST_NRM_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = (DIV_N_W'(q_mag) << NORM_SHIFT) + DIV_N_W'(root_reg >> 1);
                div_req.divisor  = root_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            max_gap_reg <= GAP_RESET;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                max_gap_reg <= cfg_wr_data;
            if ((state_reg == ST_PUSH) && (fill_reg < CNT_W'(BUFFER_DEPTH)))
                fill_reg <= fill_reg + CNT_W'(1);
            if ((state_reg == ST_CMP) && !early && (passed || gap_bad))
            begin
                head_reg <= slot_add(head_reg, CNT_W'(1));
                fill_reg <= fill_reg - CNT_W'(1);
            end
            unique case (state_reg) inside
                ST_CMP, ST_COPY, ST_SQRT_WAIT:
                    idx_reg <= '0;
                ST_DIV_WAIT:
                    if (div_done)
                        idx_reg <= (idx_reg == CH_W'(NUM_CHAN - 1)) ? '0 : idx_reg + CH_W'(1);
                ST_SQ_ADD:
                    idx_reg <= (idx_reg == CH_W'(NUM_QUAT - 1)) ? '0 : idx_reg + CH_W'(1);
                ST_NRM_WAIT:
                    if (div_done)
                        idx_reg <= idx_reg + CH_W'(1);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                req_reg      <= req_type;
                stamp_reg    <= stamp;
                in_entry_reg <= {quat_z, quat_y, quat_x, quat_w,
                                 accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x, stamp};
                status_reg   <= STAT_FEW;
                ostamp_reg   <= '0;
                for (int i = 0; i < NUM_CHAN; i++)
                    ch_res_reg[i] <= '0;
                for (int i = 0; i < NUM_QUAT; i++)
                    qn_reg[i] <= '0;
            end
            ST_PUSH:
                status_reg <= (fill_reg < CNT_W'(BUFFER_DEPTH)) ? STAT_OK : STAT_FULL;
            ST_RD1:
                e0_reg <= ram_rdata;
            ST_RD2:
                e1_reg <= ram_rdata;
            ST_CMP:
            begin
                wa_reg <= hi_gap[GAP_W-1:0];
                wb_reg <= lo_gap[GAP_W-1:0];
                d_reg  <= span[W_W-1:0];
                if (early)
                    status_reg <= STAT_EARLY;
                else if (!passed && gap_bad)
                    status_reg <= STAT_GAP;
                else if (!passed)
                begin
                    status_reg <= STAT_OK;
                    ostamp_reg <= stamp_reg;
                end
            end
            ST_COPY:
            begin
                for (int i = 0; i < NUM_CHAN; i++)
                    ch_res_reg[i] <= chan_val(e0_reg, CH_W'(i));
                sum_reg <= '0;
            end
            ST_MUL_A:
                prod_reg <= mul_p;
            ST_MUL_B:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            ST_DIV_GO:
                neg_reg <= num_neg;
            ST_DIV_WAIT:
            begin
                sum_reg <= '0;
                if (div_done)
                    ch_res_reg[idx_reg] <= neg_reg ? MOTION_W'(-div_quot[MOTION_W-1:0])
                                                   : $signed(div_quot[MOTION_W-1:0]);
            end
            ST_SQ_MUL:
                prod_reg <= mul_p;
            ST_SQ_ADD:
                sum_reg <= sum_reg + prod_reg[SUM_W-1:0];
            ST_SQRT_WAIT:
                if (sqrt_done)
                    root_reg <= sqrt_root;
            ST_NRM_GO:
                neg_reg <= q_neg;
            ST_NRM_WAIT:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                        qn_reg[idx_reg[1:0]] <= (div_quot > DIV_N_W'(32768)) ? 16'sh8000
                                                : QUAT_W'(-div_quot[QUAT_W:0]);
                    else
                        qn_reg[idx_reg[1:0]] <= (div_quot > DIV_N_W'(32767)) ? 16'sh7fff
                                                : $signed(div_quot[QUAT_W-1:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status      = status_reg;
    assign out_stamp   = (req_reg == REQ_SYNC) ? ostamp_reg : '0;
    assign out_gyro_x  = ch_res_reg[0];
    assign out_gyro_y  = ch_res_reg[1];
    assign out_gyro_z  = ch_res_reg[2];
    assign out_accel_x = ch_res_reg[3];
    assign out_accel_y = ch_res_reg[4];
    assign out_accel_z = ch_res_reg[5];
    assign out_quat_w  = qn_reg[0];
    assign out_quat_x  = qn_reg[1];
    assign out_quat_y  = qn_reg[2];
    assign out_quat_z  = qn_reg[3];

    `IMUSYNC_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(BUFFER_DEPTH))
    `IMUSYNC_ASSERT_NEXT(a_accept_busy, accept, busy)
    `IMUSYNC_ASSERT_NEXT(a_done_idle, done, !busy && !done)
    `IMUSYNC_ASSERT_NOW(a_unit_excl, div_req.start, !sqrt_start)

endmodule

/* test/tb_top.sv */
module tb_top;
    import imusync_pkg::*;

    typedef struct {
        status_t                         st;
        logic [STAMP_W-1:0]              ts;
        logic signed [MOTION_W-1:0]      m [NUM_MOTION];
        logic signed [QUAT_W-1:0]        q [NUM_QUAT];
    } sample_res_t;

    typedef struct {
        bit                              is_cfg;
        logic [GAP_W-1:0]                gap;
        logic                            kind;
        logic [STAMP_W-1:0]              ts;
        logic signed [MOTION_W-1:0]      m [NUM_MOTION];
        logic signed [QUAT_W-1:0]        q [NUM_QUAT];
        bit                              typed;
        status_t                         st;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [GAP_W-1:0]              cfg_wr_data;
    logic                          start;
    logic                          busy;
    logic                          req_type;
    logic [STAMP_W-1:0]            stamp;
    logic signed [MOTION_W-1:0]    gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z;
    logic signed [QUAT_W-1:0]      quat_w, quat_x, quat_y, quat_z;
    logic                          done;
    logic [STATUS_W-1:0]           status;
    logic [STAMP_W-1:0]            out_stamp;
    logic signed [MOTION_W-1:0]    out_gyro_x, out_gyro_y, out_gyro_z;
    logic signed [MOTION_W-1:0]    out_accel_x, out_accel_y, out_accel_z;
    logic signed [QUAT_W-1:0]      out_quat_w, out_quat_x, out_quat_y, out_quat_z;

    imu_sample_time_sync_interpolator dut (.*);

    // shadow ring buffer
    logic [STAMP_W-1:0]            ring_ts [BUFFER_DEPTH];
    logic signed [MOTION_W-1:0]    ring_m  [BUFFER_DEPTH][NUM_MOTION];
    logic signed [QUAT_W-1:0]      ring_q  [BUFFER_DEPTH][NUM_QUAT];
    int                            ring_head;
    int                            ring_fill;
    logic [GAP_W-1:0]              gap_limit;

    sample_res_t                   pending_results[$];
    stim_row_t                     directed_rows[$];
    int                            mismatch_count;
    int                            idle_pct;
    logic [STAMP_W-1:0]            time_base;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint rounded_div(longint num, longint unsigned den);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   quo;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = (mag + den / 2) / den;
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int ring_slot(int k);
        return (ring_head + k) % BUFFER_DEPTH;
    endfunction

    function automatic sample_res_t interpolate_sample(stim_row_t r);
        sample_res_t      res;
        bit               decided;
        longint unsigned  t0, t1, tgt, d, sq_sum, rt;
        longint           wa, wb, a0, a1, v;
        longint           qv [NUM_QUAT];
        int               s0, s1;
        res.st = STAT_OK;
        res.ts = '0;
        foreach (res.m[i]) res.m[i] = '0;
        foreach (res.q[i]) res.q[i] = '0;
        tgt = 64'(r.ts);
        if (r.kind == REQ_PUSH)
        begin
            if (ring_fill >= BUFFER_DEPTH)
                res.st = STAT_FULL;
            else
            begin
                s0 = ring_slot(ring_fill);
                ring_ts[s0] = r.ts;
                foreach (r.m[i]) ring_m[s0][i] = r.m[i];
                foreach (r.q[i]) ring_q[s0][i] = r.q[i];
                ring_fill++;
            end
            return res;
        end
        decided = 0;
        while (ring_fill >= 2)
        begin
            t0 = 64'(ring_ts[ring_slot(0)]);
            t1 = 64'(ring_ts[ring_slot(1)]);
            if (t0 > tgt)
            begin
                res.st = STAT_EARLY;
                decided = 1;
                break;
            end
            if (t1 < tgt)
            begin
                ring_head = (ring_head + 1) % BUFFER_DEPTH;
                ring_fill--;
                continue;
            end
            if (tgt - t0 > 64'(gap_limit) || t1 - tgt > 64'(gap_limit))
            begin
                ring_head = (ring_head + 1) % BUFFER_DEPTH;
                ring_fill--;
                res.st = STAT_GAP;
                decided = 1;
            end
            break;
        end
        if (!decided && ring_fill < 2)
        begin
            res.st = STAT_FEW;
            decided = 1;
        end
        if (decided)
            return res;
        s0 = ring_slot(0);
        s1 = ring_slot(1);
        t0 = 64'(ring_ts[s0]);
        t1 = 64'(ring_ts[s1]);
        d = t1 - t0;
        wa = t1 - tgt;
        wb = tgt - t0;
        res.ts = r.ts;
        for (int i = 0; i < NUM_MOTION; i++)
        begin
            a0 = 64'(ring_m[s0][i]);
            a1 = 64'(ring_m[s1][i]);
            res.m[i] = MOTION_W'((d == 0) ? a0 : rounded_div(a0 * wa + a1 * wb, d));
        end
        sq_sum = 0;
        for (int i = 0; i < NUM_QUAT; i++)
        begin
            a0 = 64'(ring_q[s0][i]);
            a1 = 64'(ring_q[s1][i]);
            qv[i] = (d == 0) ? a0 : rounded_div(a0 * wa + a1 * wb, d);
            sq_sum += qv[i] * qv[i];
        end
        if (sq_sum != 0)
        begin
            rt = int_sqrt(sq_sum << NORM_SHIFT);
            for (int i = 0; i < NUM_QUAT; i++)
            begin
                v = rounded_div(qv[i] * (64'sd1 <<< NORM_SHIFT), rt);
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                res.q[i] = QUAT_W'(v);
            end
        end
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gap(logic [GAP_W-1:0] g);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gap_limit = g;
        @(posedge clk);
    endtask

    task automatic send_transaction(stim_row_t r);
        sample_res_t pred;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        req_type <= r.kind;
        stamp <= r.ts;
        gyro_x <= r.m[0]; gyro_y <= r.m[1]; gyro_z <= r.m[2];
        accel_x <= r.m[3]; accel_y <= r.m[4]; accel_z <= r.m[5];
        quat_w <= r.q[0]; quat_x <= r.q[1]; quat_y <= r.q[2]; quat_z <= r.q[3];
        do
            @(posedge clk);
        while (busy);
        pred = interpolate_sample(r);
        if (r.typed)
        begin
            pred.st = r.st;
            pred.ts = '0;
            foreach (pred.m[i]) pred.m[i] = '0;
            foreach (pred.q[i]) pred.q[i] = '0;
        end
        pending_results.insert(pending_results.size(), pred);
    endtask

    function automatic stim_row_t make_row(logic kind, logic [STAMP_W-1:0] ts,
                                           logic signed [MOTION_W-1:0] mv,
                                           logic signed [QUAT_W-1:0] qv,
                                           bit typed, status_t st);
        stim_row_t r;
        r.is_cfg = 0;
        r.gap = '0;
        r.kind = kind;
        r.ts = ts;
        foreach (r.m[i]) r.m[i] = mv ^ MOTION_W'(i * 32'h1357);
        foreach (r.q[i]) r.q[i] = qv;
        r.typed = typed;
        r.st = st;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [GAP_W-1:0] g);
        stim_row_t r;
        r = make_row(REQ_PUSH, '0, '0, '0, 0, STAT_OK);
        r.is_cfg = 1;
        r.gap = g;
        return r;
    endfunction

    function automatic void add_row(stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t        r;
        int               sel, k;
        longint unsigned  lo, span, step_max;
        r = make_row(REQ_PUSH, '0, '0, '0, 0, STAT_OK);
        foreach (r.m[i]) r.m[i] = $urandom;
        foreach (r.q[i]) r.q[i] = ($urandom_range(9) == 0) ? 16'sh8000 : QUAT_W'($urandom);
        step_max = (gap_limit == 0) ? 3 : 2 * longint'(gap_limit);
        if (step_max > 32'h00FF_FFFF) step_max = 32'h00FF_FFFF;
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            time_base = time_base + $urandom_range(0, int'(step_max));
            r.ts = time_base;
            if (sel < 4)
                r.ts = time_base - $urandom_range(0, 1000);
        end
        else if (sel < 90 && ring_fill > 0)
        begin
            r.kind = REQ_SYNC;
            k = $urandom_range(0, ring_fill - 1);
            lo = 64'(ring_ts[ring_slot(k)]);
            r.ts = STAMP_W'(lo);
            if (k + 1 < ring_fill && 64'(ring_ts[ring_slot(k + 1)]) > lo
                && $urandom_range(3) != 0)
            begin
                span = 64'(ring_ts[ring_slot(k + 1)]) - lo;
                if (span > 32'h7FFF_FFFF) span = 32'h7FFF_FFFF;
                r.ts = STAMP_W'(lo + $urandom_range(0, int'(span)));
            end
        end
        else
        begin
            r.kind = REQ_SYNC;
            r.ts = ($urandom_range(1) == 0) ? STAMP_W'({$urandom, $urandom})
                                            : STAMP_W'(time_base - $urandom_range(0, 99));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        sample_res_t exp_r;
        bit          bad;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d stamp %0h", status, out_stamp);
            end
            else
            begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                bad = (status !== exp_r.st) || (out_stamp !== exp_r.ts)
                    || (out_gyro_x !== exp_r.m[0]) || (out_gyro_y !== exp_r.m[1])
                    || (out_gyro_z !== exp_r.m[2]) || (out_accel_x !== exp_r.m[3])
                    || (out_accel_y !== exp_r.m[4]) || (out_accel_z !== exp_r.m[5])
                    || (out_quat_w !== exp_r.q[0]) || (out_quat_x !== exp_r.q[1])
                    || (out_quat_y !== exp_r.q[2]) || (out_quat_z !== exp_r.q[3]);
                if (bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch exp: st %0d ts %0h m %p q %p",
                                 exp_r.st, exp_r.ts, exp_r.m, exp_r.q);
                        $write("         got: st %0d ts %0h m %0h %0h %0h", status, out_stamp,
                               out_gyro_x, out_gyro_y, out_gyro_z);
                        $display(" %0h %0h %0h q %0h %0h %0h %0h",
                                 out_accel_x, out_accel_y, out_accel_z,
                                 out_quat_w, out_quat_x, out_quat_y, out_quat_z);
                    end
                end
            end
        end
    end

    initial
    begin
        #200000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        start = 1'b0;
        req_type = REQ_PUSH;
        stamp = '0;
        {gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z} = '0;
        {quat_w, quat_x, quat_y, quat_z} = '0;
        mismatch_count = 0;
        ring_head = 0;
        ring_fill = 0;
        gap_limit = GAP_RESET;
        idle_pct = 30;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(make_row(REQ_SYNC, '0, '0, '0, 1, STAT_FEW));
        add_row(make_row(REQ_PUSH, 48'd1000, 32'sh7FFF_FFFF, 16'sh7FFF, 1, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'd1000, '0, '0, 1, STAT_FEW));
        add_row(make_row(REQ_PUSH, 48'd1000, 32'sh8000_0000, 16'sh8000, 1, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'd1000, '0, '0, 0, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'd999, '0, '0, 1, STAT_EARLY));
        add_row(make_row(REQ_PUSH, 48'd3000, 32'sh0001_8000, '0, 1, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'd2000, '0, '0, 0, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'd2001, '0, '0, 0, STAT_OK));
        add_row(make_row(REQ_PUSH, 48'd5000, -32'sd1, -16'sd1, 1, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'd2999, '0, '0, 0, STAT_OK));
        add_row(cfg_row('0));
        add_row(make_row(REQ_SYNC, 48'd2500, '0, '0, 1, STAT_GAP));
        add_row(make_row(REQ_SYNC, 48'd3000, '0, '0, 1, STAT_GAP));
        add_row(make_row(REQ_SYNC, 48'd5000, '0, '0, 1, STAT_FEW));
        add_row(cfg_row(24'hFF_FFFF));
        for (int i = 1; i < BUFFER_DEPTH; i++)
            add_row(make_row(REQ_PUSH, 48'd5000 + i * 48'd4_000_000,
                             32'sd1 <<< i, 16'sd1 <<< i, 1, STAT_OK));
        add_row(make_row(REQ_PUSH, 48'hFFFF_FFFF_FFFF, '0, '0, 1, STAT_FULL));
        add_row(make_row(REQ_SYNC, 48'd5000 + 48'd50_000_000, '0, '0, 0, STAT_OK));
        add_row(make_row(REQ_SYNC, 48'hFFFF_FFFF_FFFF, '0, '0, 1, STAT_FEW));
        add_row(cfg_row(GAP_RESET));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                start <= 1'b0;
                write_gap(directed_rows[i].gap);
            end
            else
                send_transaction(directed_rows[i]);
        end

        time_base = {8'h00, $urandom, 8'h00};
        for (int ph = 0; ph < 3; ph++)
        begin
            start <= 1'b0;
            case (ph)
                0: write_gap($urandom_range(100, 5000));
                1: write_gap(24'hFF_FFFF);
                default: write_gap('0);
            endcase
            idle_pct = (ph == 0) ? 30 : (ph == 1) ? 69 : 0;
            for (int n = 0; n < 200; n++)
                send_transaction(random_row());
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
